[sv/ccb_pkg.sv]
package ccb_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS      = 16;
  localparam int OUT_BITS         = 17;
  localparam int CFG_BITS         = 7;

  // configuration and sizing defaults
  localparam int MAX_ANTENNAS_DEF = 64;
  localparam int COUNT_RESET      = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OUT_BITS-1:0]    beam_t;
  typedef logic [CFG_BITS-1:0]           cfg_t;

endpackage

[sv/ccb_stream_if.sv]
// antenna sample channel
interface sample_if;
  logic             valid;
  logic             ready;
  ccb_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// beam result channel
interface beam_if;
  logic           valid;
  logic           ready;
  ccb_pkg::beam_t beam_value;

  modport source (output valid, output beam_value, input ready);
  modport sink   (input valid, input beam_value, output ready);
endinterface

[sv/ccb_divsqrt.sv]
module ccb_divsqrt #(
  parameter int MAG_W = 45,
  parameter int DIV_W = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [MAG_W-1:0]         mag,
  input  logic [DIV_W-1:0]         divisor,
  output logic                     done,
  output logic [(MAG_W+1)/2-1:0]   root
);

  localparam int ROOT_W = (MAG_W + 1) / 2;
  localparam int DW     = 2 * ROOT_W;
  localparam int CS_W   = (DIV_W + 1 > ROOT_W + 3) ? DIV_W + 1 : ROOT_W + 3;
  localparam int CNT_W  = $clog2(DW + 1);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DIV  = 2'd1;
  localparam logic [1:0] P_ROOT = 2'd2;

  logic [1:0]        phase;
  logic [CNT_W-1:0]  count;
  logic [DW-1:0]     work;
  logic [CS_W-1:0]   rem;
  logic [DIV_W-1:0]  div_q;
  logic [ROOT_W-1:0] root_q;

  logic [CS_W-1:0]   cs_a;
  logic [CS_W-1:0]   cs_b;
  logic [CS_W:0]     cs_diff;
  logic              cs_ge;

  // shared compare-subtract: restoring divide step or root digit step
  always_comb begin
    if (phase == P_ROOT) begin
      cs_a = {rem[CS_W-3:0], work[DW-1 -: 2]};
      cs_b = CS_W'({root_q, 2'b01});
    end else begin
      cs_a = {rem[CS_W-2:0], work[DW-1]};
      cs_b = CS_W'(div_q);
    end
    cs_diff = {1'b0, cs_a} - {1'b0, cs_b};
    cs_ge   = ~cs_diff[CS_W];
  end

  // sequencer: one quotient bit per cycle, then one root bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            work  <= DW'(mag);
            div_q <= divisor;
            rem   <= '0;
            count <= CNT_W'(DW);
            phase <= P_DIV;
          end
        end
        P_DIV: begin
          work  <= {work[DW-2:0], cs_ge};
          count <= count - 1'b1;
          if (count == CNT_W'(1)) begin
            rem    <= '0;
            root_q <= '0;
            count  <= CNT_W'(ROOT_W);
            phase  <= P_ROOT;
          end else begin
            rem <= cs_ge ? cs_diff[CS_W-1:0] : cs_a;
          end
        end
        P_ROOT: begin
          rem    <= cs_ge ? cs_diff[CS_W-1:0] : cs_a;
          root_q <= {root_q[ROOT_W-2:0], cs_ge};
          work   <= {work[DW-3:0], 2'b00};
          count  <= count - 1'b1;
          if (count == CNT_W'(1)) begin
            phase <= P_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign root = root_q;

  // checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> phase == P_IDLE) else $error("start while engine busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> phase == P_IDLE && $past(phase) == P_ROOT) else $error("stray done");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (phase == P_DIV || phase == P_ROOT) |-> count != '0) else $error("step count ran out");

endmodule

[sv/cross_correlation_beam.sv]
// Pairwise cross-correlation beam with signed square-root output.
// in_ch carries one signed antenna sample per transfer; the samples of one time
// step arrive antenna by antenna. out_ch carries one beam_value per time step.
// cfg_we/cfg_wdata set antenna_count (saturated to 2..MAX_ANTENNAS); write it
// only while the block is idle.
// A sample that does not close its step is taken in S_IDLE, where the multiplier
// forms sample * prefix sum, and its product is then added into the pair
// accumulator in S_ACC. The closing sample then goes through S_LAUNCH and the
// shared compare-subtract engine: a restoring divide by n(n-1)/2 over DW quotient
// bits, then a digit square root over DW/2 root bits, where DW is the
// accumulator width 2*SAMPLE_BITS + 2*clog2(MAX_ANTENNAS) + 1 rounded up to even
// (46 at the defaults). in_ch.ready is low while any of this is running. The
// result sits in an output register, so the next step's samples are taken
// while it waits; if out_ch stalls until another step closes, the engine holds
// its root until the register frees. Reset clears the step state, drops
// out_ch.valid and sets antenna_count to 2.
module cross_correlation_beam #(
  parameter int MAX_ANTENNAS = ccb_pkg::MAX_ANTENNAS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  ccb_pkg::cfg_t cfg_wdata,
  sample_if.sink        in_ch,
  beam_if.source        out_ch
);

  import ccb_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ANTENNAS + 1);
  localparam int PS_W   = SAMPLE_BITS + $clog2(MAX_ANTENNAS) + 1;
  localparam int PROD_W = PS_W + SAMPLE_BITS;
  localparam int ACC_W  = 2 * SAMPLE_BITS + 2 * $clog2(MAX_ANTENNAS) + 1;
  localparam int PAIR_W = $clog2(MAX_ANTENNAS * (MAX_ANTENNAS - 1) / 2 + 1);
  localparam int ROOT_W = (ACC_W + 1) / 2;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACC    = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_HOLD   = 3'd4;

  logic [2:0]               state;
  cfg_t                     antenna_count;
  logic signed [PS_W-1:0]   prefix_sum;
  logic signed [ACC_W-1:0]  pair_acc;
  logic signed [PROD_W-1:0] product;
  logic [IDX_W-1:0]         index;
  logic                     neg;
  logic                     out_valid;
  beam_t                    out_data;

  logic [IDX_W-1:0]         n_eff;
  logic [2*IDX_W-1:0]       n_prod;
  logic [PAIR_W-1:0]        pairs;
  logic [ACC_W-1:0]         mag;
  logic signed [PROD_W-1:0] mult_out;
  logic                     eng_start;
  logic                     eng_done;
  logic [ROOT_W-1:0]        eng_root;
  logic [ROOT_W:0]          signed_root;
  logic                     out_free;
  logic                     load;

  // effective antenna count and pair count
  always_comb begin
    if (32'(antenna_count) < 32'd2) begin
      n_eff = IDX_W'(2);
    end else if (32'(antenna_count) > 32'(MAX_ANTENNAS)) begin
      n_eff = IDX_W'(MAX_ANTENNAS);
    end else begin
      n_eff = IDX_W'(antenna_count);
    end
    n_prod = {{IDX_W{1'b0}}, n_eff} * {{IDX_W{1'b0}}, n_eff - 1'b1};
    pairs  = n_prod[PAIR_W:1];
  end

  // sample times sum of earlier samples
  assign mult_out = in_ch.sample * prefix_sum;

  // magnitude of the pair sum and sign-applied root
  assign mag         = pair_acc[ACC_W-1] ? $unsigned(-pair_acc) : $unsigned(pair_acc);
  assign signed_root = neg ? ((ROOT_W+1)'(0) - {1'b0, eng_root}) : {1'b0, eng_root};

  assign eng_start = (state == S_LAUNCH);
  assign out_free  = ~out_valid | out_ch.ready;
  assign load      = ((state == S_RUN && eng_done) || state == S_HOLD) && out_free;

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.beam_value = out_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      antenna_count <= cfg_t'(COUNT_RESET);
    end else if (cfg_we) begin
      antenna_count <= cfg_wdata;
    end
  end

  // step sequencer and accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prefix_sum <= '0;
      pair_acc   <= '0;
      index      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            product    <= mult_out;
            prefix_sum <= prefix_sum + PS_W'(in_ch.sample);
            index      <= index + 1'b1;
            state      <= S_ACC;
          end
        end
        S_ACC: begin
          pair_acc <= pair_acc + ACC_W'(product);
          state    <= (index >= n_eff) ? S_LAUNCH : S_IDLE;
        end
        S_LAUNCH: begin
          neg        <= pair_acc[ACC_W-1];
          prefix_sum <= '0;
          pair_acc   <= '0;
          index      <= '0;
          state      <= S_RUN;
        end
        S_RUN: begin
          if (eng_done) begin
            state <= out_free ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= signed_root[OUT_BITS-1:0];
    end
  end

  // divide and square-root engine
  ccb_divsqrt #(
    .MAG_W (ACC_W),
    .DIV_W (PAIR_W)
  ) u_divsqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (eng_start),
    .mag     (mag),
    .divisor (pairs),
    .done    (eng_done),
    .root    (eng_root)
  );

  // checks
  a_launch_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_LAUNCH |=> index == '0 && prefix_sum == '0 && pair_acc == '0)
    else $error("step state not cleared at launch");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> state == S_RUN) else $error("engine done outside run");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RUN || state == S_HOLD))
    else $error("result without engine completion");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    index <= IDX_W'(MAX_ANTENNAS)) else $error("antenna index overflow");

endmodule

[tb/tb_cross_correlation_beam.sv]
module tb_cross_correlation_beam;
  timeunit 1ns;
  timeprecision 1ps;

  import ccb_pkg::*;

  localparam int MAX_ANT      = MAX_ANTENNAS_DEF;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 145;

  typedef enum logic {ROW_SAMPLE, ROW_COUNT} row_kind_t;
  typedef enum int {MIX_NOISE, MIX_COMMON, MIX_SWING, MIX_EDGE} mix_t;

  typedef struct packed {
    row_kind_t kind;
    cfg_t      count;
    sample_t   smp;
    logic      typed;
    beam_t     want;
  } script_row_t;

  // directed stimulus: typed results only where obvious
  localparam int N_ROWS = 28;
  localparam script_row_t SCRIPT [N_ROWS] = '{
    '{ROW_SAMPLE, 7'd0, 16'sd0,      1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd0,      1'b1, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd32767,  1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd32767,  1'b1, 17'sd32767},
    '{ROW_SAMPLE, 7'd0, -16'sd32768, 1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, -16'sd32768, 1'b1, 17'sd32768},
    '{ROW_SAMPLE, 7'd0, -16'sd32768, 1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd32767,  1'b1, -17'sd32767},
    '{ROW_SAMPLE, 7'd0, 16'sd1,      1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, -16'sd1,     1'b1, -17'sd1},
    '{ROW_COUNT,  7'd0, 16'sd0,      1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd5,      1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd3,      1'b1, 17'sd3},
    '{ROW_COUNT,  7'd1, 16'sd0,      1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, -16'sd7,     1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd7,      1'b1, -17'sd7},
    '{ROW_COUNT,  7'd3, 16'sd0,      1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd2,      1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd3,      1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd4,      1'b0, 17'sd0},
    '{ROW_COUNT,  7'd4, 16'sd0,      1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd100,    1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd100,    1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd100,    1'b0, 17'sd0},
    '{ROW_COUNT,  7'd2, 16'sd0,      1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd100,    1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, -16'sd21846, 1'b0, 17'sd0},
    '{ROW_SAMPLE, 7'd0, 16'sd21845,  1'b0, 17'sd0}
  };

  // antenna counts per random phase, extremes included
  localparam cfg_t PHASE_COUNT [PHASES] = '{
    7'd127, 7'd2, 7'd5, 7'd1, 7'd64, 7'd17, 7'd0, 7'd65, 7'd3
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  cfg_t cfg_wdata;

  sample_if in_ch ();
  beam_if   out_ch ();

  cross_correlation_beam DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // correlator shadow state
  cfg_t                count_q;
  logic signed [22:0]  run_sum;
  logic signed [42:0]  pair_acc;
  int unsigned         got_cnt;

  beam_t beam_q [$];
  int    errors = 0;
  int    samples_sent;
  int    beams_seen = 0;
  int    counts_written;
  int    src_idle_pct;
  int    dst_idle_pct;
  int    stall_cycles = 0;

  // per-step stimulus style
  mix_t  step_mix;
  int    step_base;
  int    step_spread;

  task automatic report_mismatch(input string what, input beam_t got, input beam_t want);
    $display("%0t ns: %s: beam_value %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // accumulate one sample; returns 1 when the step closes
  function automatic bit correlate(input sample_t x, output beam_t beam);
    int unsigned       n;
    longint            acc64;
    longint unsigned   pairs;
    longint unsigned   mag;
    longint unsigned   trial;
    longint unsigned   root;
    n = (count_q < 2) ? 2 : ((count_q > MAX_ANT) ? MAX_ANT : count_q);
    pair_acc = pair_acc + x * run_sum;
    run_sum  = run_sum + x;
    got_cnt++;
    beam = '0;
    if (got_cnt < n) return 1'b0;
    pairs = (n * (n - 1)) / 2;
    acc64 = pair_acc;
    mag   = (acc64 < 0) ? -acc64 : acc64;
    mag   = mag / pairs;
    root  = 0;
    // bitwise floor square root, top bit down
    for (int b = 21; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= mag) root = trial;
    end
    beam = (acc64 < 0) ? -beam_t'(root) : beam_t'(root);
    run_sum  = '0;
    pair_acc = '0;
    got_cnt  = 0;
    return 1'b1;
  endfunction

  // random sample, shaped per step: noise, strong positive or negative correlation, or edge values
  function automatic sample_t next_sample();
    int v;
    if (got_cnt == 0) begin
      step_mix    = mix_t'($urandom_range(3));
      step_base   = int'($urandom_range(65535)) - 32768;
      step_spread = 1 << $urandom_range(15);
    end
    case (step_mix)
      MIX_NOISE: v = int'($urandom_range(65535)) - 32768;
      MIX_COMMON, MIX_SWING: begin
        v = step_base + int'($urandom_range(2 * step_spread)) - step_spread;
        if (step_mix == MIX_SWING && got_cnt[0]) v = -v;
      end
      default: begin
        case ($urandom_range(4))
          0: v = 32767;
          1: v = -32768;
          2: v = 1;
          3: v = -1;
          default: v = 0;
        endcase
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return sample_t'(v);
  endfunction

  // offer one sample; on transfer, record the step result if it closes
  task automatic push_sample(input sample_t s, input logic typed, input beam_t want);
    beam_t beam;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
    if (correlate(s, beam)) beam_q.push_back(typed ? want : beam);
  endtask

  // hold off until all results are back and the block has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (beam_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input cfg_t v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    count_q = v;
    counts_written++;
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= dst_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      beams_seen++;
      if (beam_q.size() == 0) begin
        report_mismatch("result with none pending", out_ch.beam_value, '0);
      end else begin
        if (out_ch.beam_value !== beam_q[0])
          report_mismatch("beam mismatch", out_ch.beam_value, beam_q[0]);
        void'(beam_q.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("cross_correlation_beam verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.sample   = '0;
    count_q        = cfg_t'(COUNT_RESET);
    run_sum        = '0;
    pair_acc       = '0;
    got_cnt        = 0;
    samples_sent   = 0;
    counts_written = 0;
    src_idle_pct   = 26;
    dst_idle_pct   = 50;
    step_mix       = MIX_NOISE;
    step_base      = 0;
    step_spread    = 1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_COUNT) write_count(SCRIPT[i].count);
      else push_sample(SCRIPT[i].smp, SCRIPT[i].typed, SCRIPT[i].want);
    end

    // random phases; each count change lands wherever the current step stands
    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        src_idle_pct = 26;
        dst_idle_pct = 50;
      end else if (p < 6) begin
        src_idle_pct = 50;
        dst_idle_pct = 26;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      write_count(PHASE_COUNT[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) push_sample(next_sample(), 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (beam_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples, %0d beam results, %0d antenna count writes",
             samples_sent, beams_seen, counts_written);
    $display("counts 0 to 127 incl. saturation, mid-step count changes, three idle patterns");
    if (errors == 0 && beam_q.size() == 0) begin
      $display("cross_correlation_beam verification clean");
    end else begin
      $display("cross_correlation_beam verification failed");
    end
    $finish;
  end

endmodule
